>>> rtl/lhls_pkg.sv
// Shared types and constants for the link health and latency selector.
// Used by the table, sequencer and top level of the block; has no dependencies of its own.
`timescale 1ns / 1ps

package lhls_pkg;

  localparam int unsigned MaxLinks = 16;
  localparam logic [7:0] FailLimitReset = 8'd3;
  localparam logic [7:0] FailCountMax = 8'hFF;

  typedef enum logic [2:0] {
    REQ_ADD     = 3'd0,
    REQ_REMOVE  = 3'd1,
    REQ_FAILURE = 3'd2,
    REQ_SUCCESS = 3'd3,
    REQ_SELECT  = 3'd4,
    REQ_CLEAR   = 3'd5
  } lhls_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_UPDATE,
    ST_RESP
  } lhls_state_e;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] latency;
    logic [7:0]  failures;
    logic        active;
  } lhls_entry_t;

endpackage

>>> rtl/lhls_table.sv
// Link table storage: one write port and one registered read port.
// Depends on lhls_pkg for the entry layout.
`timescale 1ns / 1ps

module lhls_table #(
  parameter int unsigned Depth = lhls_pkg::MaxLinks,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  lhls_pkg::lhls_entry_t wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output lhls_pkg::lhls_entry_t rdata_o
);

  lhls_pkg::lhls_entry_t mem [Depth];
  lhls_pkg::lhls_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lhls_ctrl.sv
// Request sequencer: scans the link table, then updates or compacts it,
// and holds the result register. Depends on lhls_pkg and drives lhls_table.
`timescale 1ns / 1ps

module lhls_ctrl #(
  parameter int unsigned MaxLinks = lhls_pkg::MaxLinks,
  localparam int unsigned AddrW = $clog2(MaxLinks),
  localparam int unsigned CntW = $clog2(MaxLinks + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            req_i,
  input  logic [15:0]           id_i,
  input  logic [15:0]           lat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_ok_o,
  output logic [15:0]           out_chosen_o,
  output logic [4:0]            out_active_o,
  output logic                  mem_we_o,
  output logic [AddrW-1:0]      mem_waddr_o,
  output lhls_pkg::lhls_entry_t mem_wdata_o,
  output logic [AddrW-1:0]      mem_raddr_o,
  input  lhls_pkg::lhls_entry_t mem_rdata_i
);

  lhls_pkg::lhls_state_e state_q, state_d;
  logic [2:0]            req_q, req_d;
  logic [15:0]           id_q, id_d, lat_q, lat_d;
  logic [CntW-1:0]       count_q, count_d, active_q, active_d, rd_idx_q, rd_idx_d;
  logic                  chk_v_q, chk_v_d;
  logic [AddrW-1:0]      chk_idx_q, chk_idx_d, slot_q, slot_d;
  logic                  found_q, found_d;
  lhls_pkg::lhls_entry_t slot_ent_q, slot_ent_d;
  logic                  best_v_q, best_v_d;
  logic [15:0]           best_lat_q, best_lat_d, best_key_q, best_key_d;
  logic                  res_ok_q, res_ok_d;
  logic [15:0]           res_id_q, res_id_d;
  logic                  out_valid_q, out_valid_d, out_ok_q, out_ok_d;
  logic [15:0]           out_chosen_q, out_chosen_d;
  logic [4:0]            out_active_q, out_active_d;
  logic [7:0]            limit_q, limit_d;

  logic            rd_more, scan_done, out_free, add_ok, better;
  logic [CntW-1:0] rd_prev;
  logic [7:0]      fail_inc;
  logic            fail_act;

  assign rd_more   = rd_idx_q < count_q;
  assign scan_done = !rd_more && !chk_v_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign add_ok    = !found_q && (count_q != CntW'(MaxLinks));
  assign rd_prev   = rd_idx_q - CntW'(1);
  assign fail_inc  = (slot_ent_q.failures == lhls_pkg::FailCountMax) ?
                     slot_ent_q.failures : slot_ent_q.failures + 8'd1;
  assign fail_act  = (fail_inc >= limit_q) ? 1'b0 : slot_ent_q.active;
  assign better    = mem_rdata_i.active &&
                     (!best_v_q || (mem_rdata_i.latency == 16'd0) ||
                      ((best_lat_q != 16'd0) && (mem_rdata_i.latency < best_lat_q)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lhls_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lhls_pkg::ST_SCAN;
      end
      lhls_pkg::ST_SCAN: begin
        if (scan_done) begin
          case (req_q) inside
            lhls_pkg::REQ_ADD:
              state_d = add_ok ? lhls_pkg::ST_UPDATE : lhls_pkg::ST_RESP;
            lhls_pkg::REQ_REMOVE:
              state_d = found_q ? lhls_pkg::ST_SHIFT : lhls_pkg::ST_RESP;
            lhls_pkg::REQ_FAILURE, lhls_pkg::REQ_SUCCESS:
              state_d = found_q ? lhls_pkg::ST_UPDATE : lhls_pkg::ST_RESP;
            default: state_d = lhls_pkg::ST_RESP;
          endcase
        end
      end
      lhls_pkg::ST_SHIFT: begin
        if (scan_done) state_d = lhls_pkg::ST_RESP;
      end
      lhls_pkg::ST_UPDATE: state_d = lhls_pkg::ST_RESP;
      lhls_pkg::ST_RESP: begin
        if (out_free) state_d = lhls_pkg::ST_IDLE;
      end
      default: state_d = lhls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_d        = req_q;
    id_d         = id_q;
    lat_d        = lat_q;
    count_d      = count_q;
    active_d     = active_q;
    rd_idx_d     = rd_idx_q;
    chk_v_d      = chk_v_q;
    chk_idx_d    = chk_idx_q;
    slot_d       = slot_q;
    found_d      = found_q;
    slot_ent_d   = slot_ent_q;
    best_v_d     = best_v_q;
    best_lat_d   = best_lat_q;
    best_key_d   = best_key_q;
    res_ok_d     = res_ok_q;
    res_id_d     = res_id_q;
    out_valid_d  = out_valid_q;
    out_ok_d     = out_ok_q;
    out_chosen_d = out_chosen_q;
    out_active_d = out_active_q;
    limit_d      = cfg_we_i ? cfg_wdata_i : limit_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = chk_idx_q;
    mem_wdata_o  = mem_rdata_i;
    mem_raddr_o  = rd_idx_q[AddrW-1:0];

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      lhls_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d    = req_i;
          id_d     = id_i;
          lat_d    = lat_i;
          rd_idx_d = '0;
          chk_v_d  = 1'b0;
          found_d  = 1'b0;
          best_v_d = 1'b0;
          res_ok_d = 1'b0;
          res_id_d = 16'd0;
        end
      end
      lhls_pkg::ST_SCAN: begin
        chk_v_d = rd_more;
        if (rd_more) begin
          rd_idx_d  = rd_idx_q + CntW'(1);
          chk_idx_d = rd_idx_q[AddrW-1:0];
        end
        if (chk_v_q) begin
          if (!found_q && (mem_rdata_i.key == id_q)) begin
            found_d    = 1'b1;
            slot_d     = chk_idx_q;
            slot_ent_d = mem_rdata_i;
          end
          if (better) begin
            best_v_d   = 1'b1;
            best_lat_d = mem_rdata_i.latency;
            best_key_d = mem_rdata_i.key;
          end
        end
        if (scan_done) begin
          case (req_q) inside
            lhls_pkg::REQ_ADD: res_ok_d = add_ok;
            lhls_pkg::REQ_REMOVE: begin
              res_ok_d = found_q;
              rd_idx_d = CntW'(slot_q) + CntW'(1);
              chk_v_d  = 1'b0;
            end
            lhls_pkg::REQ_FAILURE, lhls_pkg::REQ_SUCCESS: res_ok_d = found_q;
            lhls_pkg::REQ_SELECT: begin
              res_ok_d = best_v_q;
              res_id_d = best_v_q ? best_key_q : 16'd0;
            end
            lhls_pkg::REQ_CLEAR: begin
              res_ok_d = 1'b1;
              count_d  = '0;
              active_d = '0;
            end
            default: res_ok_d = 1'b0;
          endcase
        end
      end
      lhls_pkg::ST_SHIFT: begin
        chk_v_d = rd_more;
        if (rd_more) begin
          rd_idx_d  = rd_idx_q + CntW'(1);
          chk_idx_d = rd_prev[AddrW-1:0];
        end
        if (chk_v_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = chk_idx_q;
          mem_wdata_o = mem_rdata_i;
        end
        if (scan_done) begin
          count_d = count_q - CntW'(1);
          if (slot_ent_q.active) active_d = active_q - CntW'(1);
        end
      end
      lhls_pkg::ST_UPDATE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = slot_q;
        mem_wdata_o = slot_ent_q;
        case (req_q)
          lhls_pkg::REQ_ADD: begin
            mem_waddr_o          = count_q[AddrW-1:0];
            mem_wdata_o.key      = id_q;
            mem_wdata_o.latency  = 16'd0;
            mem_wdata_o.failures = 8'd0;
            mem_wdata_o.active   = 1'b1;
            count_d              = count_q + CntW'(1);
            active_d             = active_q + CntW'(1);
          end
          lhls_pkg::REQ_FAILURE: begin
            mem_wdata_o.failures = fail_inc;
            mem_wdata_o.active   = fail_act;
            if (slot_ent_q.active && !fail_act) active_d = active_q - CntW'(1);
          end
          default: begin
            if (lat_q != 16'd0) mem_wdata_o.latency = lat_q;
            mem_wdata_o.active = 1'b1;
            if (!slot_ent_q.active) active_d = active_q + CntW'(1);
          end
        endcase
      end
      lhls_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_ok_d     = res_ok_q;
          out_chosen_d = res_id_q;
          out_active_d = 5'(active_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lhls_pkg::ST_IDLE;
      count_q     <= '0;
      active_q    <= '0;
      rd_idx_q    <= '0;
      chk_v_q     <= 1'b0;
      found_q     <= 1'b0;
      best_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= lhls_pkg::FailLimitReset;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      active_q    <= active_d;
      rd_idx_q    <= rd_idx_d;
      chk_v_q     <= chk_v_d;
      found_q     <= found_d;
      best_v_q    <= best_v_d;
      out_valid_q <= out_valid_d;
      limit_q     <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    id_q         <= id_d;
    lat_q        <= lat_d;
    chk_idx_q    <= chk_idx_d;
    slot_q       <= slot_d;
    slot_ent_q   <= slot_ent_d;
    best_lat_q   <= best_lat_d;
    best_key_q   <= best_key_d;
    res_ok_q     <= res_ok_d;
    res_id_q     <= res_id_d;
    out_ok_q     <= out_ok_d;
    out_chosen_q <= out_chosen_d;
    out_active_q <= out_active_d;
  end

  assign in_ready_o   = (state_q == lhls_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_ok_o     = out_ok_q;
  assign out_chosen_o = out_chosen_q;
  assign out_active_o = out_active_q;

endmodule

>>> rtl/link_health_latency_selector_top.sv
// Top level of the link health and latency selector: stream ports,
// configuration register port, sequencer and table. Depends on lhls_pkg.
//
//   Channel   Direction  Contents
//   s_axis    in         request item: kind in tuser, link id and latency in tdata
//   m_axis    out        result item: ok flag in tuser, chosen id and active count in tdata
//   cfg       in         failure limit write, one register
//
// Every request scans the table through the single read port of the memory; a remove then
// shifts the later entries down, and an add, failure or success that changes the table
// writes back one entry. A new item is taken only after the result of the previous one has
// been put out. After reset the table is empty and the failure limit is 3.
// A result still waiting on m_axis holds the next request in its response state.
`timescale 1ns / 1ps

module link_health_latency_selector_top #(
  parameter int unsigned MaxLinks = lhls_pkg::MaxLinks,
  localparam int unsigned AddrW = $clog2(MaxLinks)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // link_id [15:0], latency [31:16]
  input  logic [2:0]  s_axis_tuser,  // req_type [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // chosen_id [15:0], active_links [20:16], zero [23:21]
  output logic [0:0]  m_axis_tuser   // ok [0]
);

  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr, mem_raddr;
  lhls_pkg::lhls_entry_t mem_wdata, mem_rdata;
  logic                  out_ok;
  logic [15:0]           out_chosen;
  logic [4:0]            out_active;

  lhls_ctrl #(
    .MaxLinks(MaxLinks)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_i        (s_axis_tuser),
    .id_i         (s_axis_tdata[15:0]),
    .lat_i        (s_axis_tdata[31:16]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_ok_o     (out_ok),
    .out_chosen_o (out_chosen),
    .out_active_o (out_active),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  lhls_table #(
    .Depth(MaxLinks)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata = {3'b000, out_active, out_chosen};
  assign m_axis_tuser = out_ok;

endmodule

>>> rtl/lhls_checker.sv
// Port-level checks for the link health and latency selector top level.
// Attached to link_health_latency_selector_top by the bind at the end.
`timescale 1ns / 1ps

module lhls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while a request is in progress");

  a_chosen_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[0] || (m_axis_tdata[15:0] == 16'd0))
    else $error("chosen id given without success");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:21] == 3'b000)
    else $error("padding bits of result item not zero");

endmodule

bind link_health_latency_selector_top lhls_checker u_lhls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> sim/link_health_latency_selector_top_tb.sv
// Self-checking testbench for link_health_latency_selector_top: directed and random requests,
// with the link table predicted in the bench and every result item checked in order.
// Depends on lhls_pkg and the top level of the block.
`timescale 1ns / 1ps

module link_health_latency_selector_top_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned RandomPerPhase = 75;
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] link_id;
    logic [15:0] latency;
  } link_req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] chosen_id;
    logic [4:0]  active_links;
  } link_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        s_valid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_data = '0;
  logic [2:0]  s_user = '0;
  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  link_req_t   pending_requests[$];
  link_reply_t expected_replies[$];
  link_req_t   next_req;
  link_reply_t want_reply;
  link_reply_t new_reply;
  int          reqs_outstanding = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        req_taken = 1'b0;
  logic [15:0] id_pool[20];

  // Bench copy of the link table and of the failure limit.
  logic [15:0] tbl_key[lhls_pkg::MaxLinks];
  logic [15:0] tbl_lat[lhls_pkg::MaxLinks];
  logic [7:0]  tbl_fail[lhls_pkg::MaxLinks];
  logic        tbl_act[lhls_pkg::MaxLinks];
  int          tbl_count = 0;
  logic [7:0]  fail_limit = lhls_pkg::FailLimitReset;

  link_health_latency_selector_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic link_reply_t apply_link_request(link_req_t rq);
    link_reply_t rp;
    int slot;
    int best;
    rp = '0;
    slot = -1;
    best = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (slot < 0 && tbl_key[i] == rq.link_id) slot = i;
    end
    case (rq.kind)
      lhls_pkg::REQ_ADD: begin
        if (slot < 0 && tbl_count < lhls_pkg::MaxLinks) begin
          tbl_key[tbl_count] = rq.link_id;
          tbl_lat[tbl_count] = '0;
          tbl_fail[tbl_count] = '0;
          tbl_act[tbl_count] = 1'b1;
          tbl_count++;
          rp.ok = 1'b1;
        end
      end
      lhls_pkg::REQ_REMOVE: begin
        if (slot >= 0) begin
          for (int i = slot; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i + 1];
            tbl_lat[i] = tbl_lat[i + 1];
            tbl_fail[i] = tbl_fail[i + 1];
            tbl_act[i] = tbl_act[i + 1];
          end
          tbl_count--;
          rp.ok = 1'b1;
        end
      end
      lhls_pkg::REQ_FAILURE: begin
        if (slot >= 0) begin
          if (tbl_fail[slot] != lhls_pkg::FailCountMax) tbl_fail[slot] = tbl_fail[slot] + 8'd1;
          if (tbl_fail[slot] >= fail_limit) tbl_act[slot] = 1'b0;
          rp.ok = 1'b1;
        end
      end
      lhls_pkg::REQ_SUCCESS: begin
        if (slot >= 0) begin
          if (rq.latency != 16'd0) tbl_lat[slot] = rq.latency;
          tbl_act[slot] = 1'b1;
          rp.ok = 1'b1;
        end
      end
      lhls_pkg::REQ_SELECT: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_act[i] && (best < 0 || tbl_lat[i] == 16'd0 ||
              (tbl_lat[best] != 16'd0 && tbl_lat[i] < tbl_lat[best]))) begin
            best = i;
          end
        end
        if (best >= 0) begin
          rp.ok = 1'b1;
          rp.chosen_id = tbl_key[best];
        end
      end
      lhls_pkg::REQ_CLEAR: begin
        tbl_count = 0;
        rp.ok = 1'b1;
      end
      default: ;
    endcase
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_act[i]) rp.active_links = rp.active_links + 5'd1;
    end
    return rp;
  endfunction

  task automatic queue_req(input logic [2:0] kind, input logic [15:0] id,
                           input logic [15:0] lat);
    link_req_t rq;
    rq.kind = kind;
    rq.link_id = id;
    rq.latency = lat;
    pending_requests = {pending_requests, rq};
    reqs_outstanding++;
  endtask

  // Mostly well-formed traffic on a small pool of ids so that the table fills up,
  // with some noise on arbitrary ids and the spare request codes.
  task automatic queue_random_req();
    int unsigned pick;
    logic [15:0] id;
    logic [15:0] lat;
    pick = $urandom_range(99, 0);
    id = id_pool[$urandom_range(19, 0)];
    if ($urandom_range(3, 0) == 0) begin
      lat = '0;
    end else if ($urandom_range(1, 0) == 1) begin
      lat = 16'($urandom_range(200, 1));
    end else begin
      lat = 16'($urandom);
    end
    if (pick < 28) begin
      queue_req(lhls_pkg::REQ_ADD, id, lat);
    end else if (pick < 36) begin
      queue_req(lhls_pkg::REQ_REMOVE, id, lat);
    end else if (pick < 56) begin
      queue_req(lhls_pkg::REQ_FAILURE, id, lat);
    end else if (pick < 76) begin
      queue_req(lhls_pkg::REQ_SUCCESS, id, lat);
    end else if (pick < 94) begin
      queue_req(lhls_pkg::REQ_SELECT, 16'($urandom), 16'($urandom));
    end else if (pick < 95) begin
      queue_req(lhls_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom));
    end else if (pick < 97) begin
      queue_req($urandom_range(1, 0) == 1 ? REQ_SPARE_HI : REQ_SPARE_LO, id, lat);
    end else begin
      queue_req(3'($urandom_range(3, 0)), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (reqs_outstanding != 0 || expected_replies.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_fail_limit(input logic [7:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_valid || req_taken) begin
        if (pending_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          s_valid <= 1'b1;
          s_data <= {next_req.latency, next_req.link_id};
          s_user <= next_req.kind;
        end else begin
          s_valid <= 1'b0;
        end
      end
      m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    req_taken = s_valid && s_axis_tready;
    if (cfg_we) fail_limit = cfg_wdata;
    if (req_taken) begin
      new_reply = apply_link_request(
          '{kind: s_user, link_id: s_data[15:0], latency: s_data[31:16]});
      expected_replies = {expected_replies, new_reply};
      reqs_outstanding--;
    end
    if (m_axis_tvalid && m_ready) begin
      if (expected_replies.size() == 0) begin
        $error("result item with no request waiting: tdata %h tuser %h",
               m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want_reply = expected_replies.pop_front();
        if (m_axis_tuser[0] !== want_reply.ok) begin
          $error("ok: expected %0d, got %0d", want_reply.ok, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tdata[15:0] !== want_reply.chosen_id) begin
          $error("chosen_id: expected %h, got %h", want_reply.chosen_id, m_axis_tdata[15:0]);
          mismatches++;
        end
        if (m_axis_tdata[20:16] !== want_reply.active_links) begin
          $error("active_links: expected %0d, got %0d", want_reply.active_links,
                 m_axis_tdata[20:16]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned lim;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < 20; i++) id_pool[i] = 16'($urandom);
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part with the failure limit at its reset value.
    queue_req(lhls_pkg::REQ_SELECT, 16'h0000, 16'h0000);
    queue_req(lhls_pkg::REQ_REMOVE, 16'h0005, 16'h0000);
    queue_req(lhls_pkg::REQ_FAILURE, 16'h0005, 16'h0000);
    queue_req(lhls_pkg::REQ_SUCCESS, 16'h0005, 16'h000A);
    queue_req(lhls_pkg::REQ_ADD, 16'h0000, 16'hFFFF);
    queue_req(lhls_pkg::REQ_ADD, 16'hFFFF, 16'h0000);
    queue_req(lhls_pkg::REQ_ADD, 16'h0000, 16'h0000);
    queue_req(lhls_pkg::REQ_SUCCESS, 16'hFFFF, 16'hFFFF);
    queue_req(lhls_pkg::REQ_SUCCESS, 16'h0000, 16'h0000);
    queue_req(lhls_pkg::REQ_SELECT, 16'hFFFF, 16'hFFFF);
    queue_req(lhls_pkg::REQ_SUCCESS, 16'h0000, 16'h0001);
    queue_req(lhls_pkg::REQ_SELECT, 16'h0000, 16'h0000);
    queue_req(lhls_pkg::REQ_ADD, 16'h1234, 16'h0000);
    queue_req(lhls_pkg::REQ_ADD, 16'h4321, 16'h0000);
    queue_req(lhls_pkg::REQ_SELECT, 16'h0000, 16'h0000);
    repeat (3) queue_req(lhls_pkg::REQ_FAILURE, 16'h0000, 16'h0000);
    queue_req(lhls_pkg::REQ_SUCCESS, 16'h0000, 16'h0000);
    queue_req(lhls_pkg::REQ_FAILURE, 16'h0000, 16'h0000);
    queue_req(REQ_SPARE_LO, 16'h1234, 16'h0001);
    queue_req(REQ_SPARE_HI, 16'h4321, 16'h0002);
    queue_req(lhls_pkg::REQ_REMOVE, 16'hFFFF, 16'h0000);
    queue_req(lhls_pkg::REQ_SELECT, 16'h0000, 16'h0000);
    queue_req(lhls_pkg::REQ_CLEAR, 16'h0000, 16'h0000);
    queue_req(lhls_pkg::REQ_SELECT, 16'h0000, 16'h0000);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: lim = 1;
        1: lim = 0;
        2: lim = 255;
        default: lim = $urandom_range(6, 2);
      endcase
      write_fail_limit(8'(lim));
      send_idle_pct = (ph == 1) ? 52 : (ph == 3) ? 35 : 0;
      recv_stall_pct = (ph == 2) ? 52 : (ph == 3) ? 35 : 0;
      repeat (RandomPerPhase) queue_random_req();
    end

    // Full table, then a failure count driven into saturation at the highest limit.
    write_fail_limit(8'd255);
    queue_req(lhls_pkg::REQ_CLEAR, 16'h0000, 16'h0000);
    for (int i = 0; i <= lhls_pkg::MaxLinks; i++) begin
      queue_req(lhls_pkg::REQ_ADD, 16'h1000 + 16'(i), 16'h0000);
    end
    queue_req(lhls_pkg::REQ_SELECT, 16'h0000, 16'h0000);
    repeat (258) queue_req(lhls_pkg::REQ_FAILURE, 16'h1005, 16'h0000);
    queue_req(lhls_pkg::REQ_SELECT, 16'h0000, 16'h0000);
    queue_req(lhls_pkg::REQ_SUCCESS, 16'h1005, 16'h0000);
    queue_req(lhls_pkg::REQ_FAILURE, 16'h1005, 16'h0000);
    queue_req(lhls_pkg::REQ_REMOVE, 16'h1000, 16'h0000);
    queue_req(lhls_pkg::REQ_REMOVE, 16'h100F, 16'h0000);
    queue_req(lhls_pkg::REQ_ADD, 16'h1000 + 16'(lhls_pkg::MaxLinks), 16'h0000);
    queue_req(lhls_pkg::REQ_SELECT, 16'h0000, 16'h0000);
    wait_idle();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lhls_pkg.sv
rtl/lhls_table.sv
rtl/lhls_ctrl.sv
rtl/link_health_latency_selector_top.sv
rtl/lhls_checker.sv
sim/link_health_latency_selector_top_tb.sv
